FILE: rtl/core/incremental_conductance_mppt_macros.svh
// Assertion macros for the incremental conductance tracker
`ifndef INCREMENTAL_CONDUCTANCE_MPPT_MACROS_SVH
`define INCREMENTAL_CONDUCTANCE_MPPT_MACROS_SVH
`ifndef SYNTHESIS
`define ICM_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICM_ASSERT_RESET(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICM_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ICM_ASSERT_RESET(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/icm_pkg.sv
package icm_pkg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [15:0] panel_voltage_mv;
        logic [14:0] panel_current_ma;
        logic [23:0] panel_power_mw;
        logic [15:0] battery_voltage_mv;
        logic [9:0]  pwm_now;
        logic        sun_present;
        logic        panel_bottleneck;
        logic        charging_active;
        logic        charger_settled;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        pwm_write;
        logic [9:0]  pwm_value;
        logic [15:0] current_limit_ma;
    } out_item_t;

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_TRACKING = 2'd1,
        MODE_HOLD     = 2'd2,
        MODE_INVALID  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd3
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL_A,
        ST_MUL_B,
        ST_TRACK,
        ST_CHECK,
        ST_HOLD_MUL,
        ST_DIV,
        ST_HOLD_DONE,
        ST_OUT
    } state_t;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERGE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNTIME        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMITED_MARGIN = 3'd7;

    localparam logic [15:0] VBAT_FLOOR  = 16'd1000;
    localparam logic [9:0]  MA_PER_A    = 10'd1000;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;
    localparam int          DIV_NUM_W   = 34;

endpackage

FILE: rtl/core/incremental_conductance_mppt.sv
// Channel   Direction  Handshake      Payload
// in        input      valid / stall  icm_pkg::in_item_t
// out       output     valid / stall  icm_pkg::out_item_t
// cfg       input      valid / ready  index (3 bits), data (24 bits)
//
// An item passes states DECIDE and OUT when the mode holds; tracking entry
// adds TRACK, a tracking tick before its step interval adds CHECK, a perturb
// step adds MUL_A, MUL_B, TRACK and CHECK, and hold entry adds HOLD_MUL,
// DIV and HOLD_DONE, where the serial current-limit divider retires one
// quotient bit per cycle. The multiply steps share one 33x17 multiplier.
// rst_n clears mode and counters; item, pwm and output regs have no reset.
// A result waits in the output register while out_stall is high.
module incremental_conductance_mppt #(
    parameter int PWM_LOW_BOUND    = 1,
    parameter int PWM_HIGH_BOUND   = 399,
    parameter int BUCK_CURRENT_MAX = 3000
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  icm_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output icm_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data
);
    import icm_pkg::*;

    `include "incremental_conductance_mppt_macros.svh"

    localparam logic [9:0]  PWM_LO = 10'(PWM_LOW_BOUND);
    localparam logic [9:0]  PWM_HI = 10'(PWM_HIGH_BOUND);
    localparam logic [15:0] LIMIT_CEIL = 16'(BUCK_CURRENT_MAX);

    logic [7:0]  max_step_reg, min_step_reg, converge_reg, stuck_limit_reg;
    logic [15:0] interval_reg, margin_reg;
    logic [23:0] runtime_reg, hold_time_reg;

    state_t      state_reg, state_next;
    mode_t       mode_reg, mode_next;
    in_item_t    item_reg, item_next;
    logic [15:0] last_v_reg, last_v_next;
    logic [15:0] last_i_reg, last_i_next;
    logic [7:0]  step_reg, step_next;
    logic [7:0]  rev_reg, rev_next;
    logic [7:0]  stuck_reg, stuck_next;
    logic [23:0] best_p_reg, best_p_next;
    logic [9:0]  best_pwm_reg, best_pwm_next;
    dir_t        dir_reg, dir_next;
    logic [31:0] session_reg, session_next;
    logic [31:0] step_time_reg, step_time_next;
    logic [31:0] hold_start_reg, hold_start_next;
    logic [15:0] limit_reg, limit_next;
    logic        track_due_reg, track_due_next;
    logic        wrote_reg, wrote_next;
    logic [9:0]  pwm_reg, pwm_next;
    logic signed [49:0] x_reg, x_next;
    logic        ov_reg, ov_next;
    out_item_t   out_reg, out_next;

    logic signed [32:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [16:0] dv, di;
    logic        div_start, div_busy;
    logic [DIV_NUM_W-1:0] div_numer, div_quot;
    logic [15:0] vbat_fl;
    logic [33:0] prod34;
    logic signed [11:0] pwm_sum;
    logic [7:0]  half;
    logic        rev;
    dir_t        dir_sel;

    assign mul_p = mul_a * mul_b;

    icm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (vbat_fl),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign cfg_ready = (state_reg == ST_IDLE) && !out_valid && !in_valid;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_step_reg    <= 8'd16;
            min_step_reg    <= 8'd1;
            converge_reg    <= 8'd4;
            stuck_limit_reg <= 8'd20;
            interval_reg    <= 16'd200;
            runtime_reg     <= 24'd60000;
            hold_time_reg   <= 24'd300000;
            margin_reg      <= 16'd100;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MAX_STEP:       max_step_reg    <= cfg_data[7:0];
                CFG_MIN_STEP:       min_step_reg    <= cfg_data[7:0];
                CFG_CONVERGE:       converge_reg    <= cfg_data[7:0];
                CFG_STUCK_LIMIT:    stuck_limit_reg <= cfg_data[7:0];
                CFG_STEP_INTERVAL:  interval_reg    <= cfg_data[15:0];
                CFG_RUNTIME:        runtime_reg     <= cfg_data;
                CFG_HOLD_TIME:      hold_time_reg   <= cfg_data;
                CFG_LIMITED_MARGIN: margin_reg      <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_DISABLED;
            last_v_reg     <= '0;
            last_i_reg     <= '0;
            step_reg       <= 8'd16;
            rev_reg        <= '0;
            stuck_reg      <= '0;
            best_p_reg     <= '0;
            best_pwm_reg   <= '0;
            dir_reg        <= DIR_NONE;
            session_reg    <= '0;
            step_time_reg  <= '0;
            hold_start_reg <= '0;
            limit_reg      <= LIMIT_CEIL;
            out_valid      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            last_v_reg     <= last_v_next;
            last_i_reg     <= last_i_next;
            step_reg       <= step_next;
            rev_reg        <= rev_next;
            stuck_reg      <= stuck_next;
            best_p_reg     <= best_p_next;
            best_pwm_reg   <= best_pwm_next;
            dir_reg        <= dir_next;
            session_reg    <= session_next;
            step_time_reg  <= step_time_next;
            hold_start_reg <= hold_start_next;
            limit_reg      <= limit_next;
            if (state_reg == ST_OUT)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        track_due_reg <= track_due_next;
        wrote_reg     <= wrote_next;
        pwm_reg       <= pwm_next;
        x_reg         <= x_next;
        ov_reg        <= ov_next;
        out_reg       <= out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        item_next       = item_reg;
        last_v_next     = last_v_reg;
        last_i_next     = last_i_reg;
        step_next       = step_reg;
        rev_next        = rev_reg;
        stuck_next      = stuck_reg;
        best_p_next     = best_p_reg;
        best_pwm_next   = best_pwm_reg;
        dir_next        = dir_reg;
        session_next    = session_reg;
        step_time_next  = step_time_reg;
        hold_start_next = hold_start_reg;
        limit_next      = limit_reg;
        track_due_next  = track_due_reg;
        wrote_next      = wrote_reg;
        pwm_next        = pwm_reg;
        x_next          = x_reg;
        ov_next         = ov_reg;
        out_next        = out_reg;
        div_start       = 1'b0;
        dv = $signed({1'b0, item_reg.panel_voltage_mv}) - $signed({1'b0, last_v_reg});
        di = $signed({2'b0, item_reg.panel_current_ma}) - $signed({1'b0, last_i_reg});
        mul_a = '0;
        mul_b = '0;
        vbat_fl = (item_reg.battery_voltage_mv < VBAT_FLOOR) ? VBAT_FLOOR
                                                             : item_reg.battery_voltage_mv;
        prod34 = {best_p_reg, 10'd0} - {6'd0, best_p_reg, 4'd0}
               - {7'd0, best_p_reg, 3'd0};
        div_numer = prod34;
        pwm_sum = '0;
        half = '0;
        rev = 1'b0;
        dir_sel = DIR_NONE;

        unique case (state_reg)
            ST_IDLE:
            begin
                wrote_next = 1'b0;
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                pwm_next   = item_reg.pwm_now;
                state_next = ST_OUT;
                if (!item_reg.charging_active)
                begin
                    if (mode_reg != MODE_DISABLED)
                    begin
                        mode_next = MODE_DISABLED;
                        step_next = max_step_reg;
                        rev_next = '0;
                        stuck_next = '0;
                        dir_next = DIR_NONE;
                    end
                end
                else
                begin
                    priority case (mode_reg)
                        MODE_DISABLED:
                        begin
                            if (item_reg.panel_bottleneck && item_reg.sun_present
                                && item_reg.charger_settled)
                            begin
                                state_next = ST_TRACK;
                                track_due_next = 1'b0;
                            end
                        end
                        MODE_TRACKING:
                        begin
                            if (!item_reg.sun_present)
                            begin
                                mode_next = MODE_DISABLED;
                                step_next = max_step_reg;
                                rev_next = '0;
                                stuck_next = '0;
                                dir_next = DIR_NONE;
                            end
                            else if ((item_reg.now_ms - step_time_reg) >= {16'd0, interval_reg})
                            begin
                                track_due_next = 1'b1;
                                state_next = ST_MUL_A;
                            end
                            else
                            begin
                                state_next = ST_CHECK;
                                track_due_next = 1'b0;
                            end
                        end
                        MODE_HOLD:
                        begin
                            if (!item_reg.sun_present ||
                                (!item_reg.panel_bottleneck && limit_reg > margin_reg))
                            begin
                                mode_next = MODE_DISABLED;
                                step_next = max_step_reg;
                                rev_next = '0;
                                stuck_next = '0;
                                dir_next = DIR_NONE;
                            end
                            else if ((item_reg.now_ms - hold_start_reg) >= {8'd0, hold_time_reg})
                            begin
                                state_next = ST_TRACK;
                                track_due_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            mode_next = MODE_DISABLED;
                            step_next = max_step_reg;
                            rev_next = '0;
                            stuck_next = '0;
                            dir_next = DIR_NONE;
                        end
                    endcase
                end
            end
            ST_MUL_A:
            begin
                mul_a  = 33'(di);
                mul_b  = $signed({1'b0, item_reg.panel_voltage_mv});
                x_next = mul_p;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                mul_a  = $signed({18'd0, item_reg.panel_current_ma});
                mul_b  = dv;
                x_next = x_reg + mul_p;
                ov_next = dv[16];
                state_next = ST_TRACK;
            end
            ST_TRACK:
            begin
                if (!track_due_reg)
                begin
                    mode_next      = MODE_TRACKING;
                    last_v_next    = item_reg.panel_voltage_mv;
                    last_i_next    = {1'b0, item_reg.panel_current_ma};
                    step_next      = max_step_reg;
                    rev_next       = '0;
                    stuck_next     = '0;
                    best_p_next    = '0;
                    best_pwm_next  = item_reg.pwm_now;
                    dir_next       = DIR_DOWN;
                    session_next   = item_reg.now_ms;
                    step_time_next = item_reg.now_ms;
                    pwm_sum = $signed({2'b0, item_reg.pwm_now}) - $signed({4'b0, max_step_reg});
                    wrote_next = 1'b1;
                    if (pwm_sum < $signed({2'b0, PWM_LO}))
                        pwm_next = PWM_LO;
                    else if (pwm_sum > $signed({2'b0, PWM_HI}))
                        pwm_next = PWM_HI;
                    else
                        pwm_next = pwm_sum[9:0];
                    state_next = ST_OUT;
                end
                else
                begin
                    if (item_reg.panel_power_mw > best_p_reg)
                    begin
                        best_p_next   = item_reg.panel_power_mw;
                        best_pwm_next = item_reg.pwm_now;
                    end
                    if (dv == '0)
                    begin
                        if (di > 0) dir_sel = DIR_UP;
                        else if (di < 0) dir_sel = DIR_DOWN;
                        else dir_sel = dir_reg;
                    end
                    else
                    begin
                        if (x_reg == '0) dir_sel = dir_reg;
                        else if (x_reg[49] ^ ov_reg) dir_sel = DIR_DOWN;
                        else dir_sel = DIR_UP;
                    end
                    rev = (dir_sel != DIR_NONE) && (dir_reg != DIR_NONE)
                          && (dir_sel != dir_reg);
                    step_next = step_reg;
                    if (rev)
                    begin
                        if (rev_reg != COUNT_MAX) rev_next = rev_reg + 1'b1;
                        if (step_reg > min_step_reg)
                        begin
                            half = {1'b0, step_reg[7:1]};
                            step_next = (half < min_step_reg) ? min_step_reg : half;
                        end
                    end
                    if (step_next >= max_step_reg && !rev)
                    begin
                        if (stuck_reg != COUNT_MAX) stuck_next = stuck_reg + 1'b1;
                    end
                    else
                    begin
                        stuck_next = '0;
                    end
                    if (dir_sel != DIR_NONE)
                    begin
                        if (dir_sel == DIR_UP)
                            pwm_sum = $signed({2'b0, item_reg.pwm_now})
                                    + $signed({4'b0, step_next});
                        else
                            pwm_sum = $signed({2'b0, item_reg.pwm_now})
                                    - $signed({4'b0, step_next});
                        if (pwm_sum < $signed({2'b0, PWM_LO}))
                            pwm_next = PWM_LO;
                        else if (pwm_sum > $signed({2'b0, PWM_HI}))
                            pwm_next = PWM_HI;
                        else
                            pwm_next = pwm_sum[9:0];
                        wrote_next = 1'b1;
                        dir_next = dir_sel;
                    end
                    last_v_next    = item_reg.panel_voltage_mv;
                    last_i_next    = {1'b0, item_reg.panel_current_ma};
                    step_time_next = item_reg.now_ms;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (track_due_reg &&
                    ((step_reg <= min_step_reg && rev_reg >= converge_reg) ||
                     stuck_reg >= stuck_limit_reg))
                    state_next = ST_HOLD_MUL;
                else if ((item_reg.now_ms - session_reg) >= {8'd0, runtime_reg})
                    state_next = ST_HOLD_MUL;
                else
                    state_next = ST_OUT;
            end
            ST_HOLD_MUL:
            begin
                div_start       = 1'b1;
                mode_next       = MODE_HOLD;
                hold_start_next = item_reg.now_ms;
                state_next      = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy) state_next = ST_HOLD_DONE;
            end
            ST_HOLD_DONE:
            begin
                if (div_quot > {18'd0, LIMIT_CEIL})
                    limit_next = LIMIT_CEIL;
                else
                    limit_next = div_quot[15:0];
                pwm_next   = best_pwm_reg;
                wrote_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    out_next.mode             = mode_reg;
                    out_next.pwm_write        = wrote_reg;
                    out_next.pwm_value        = wrote_reg ? pwm_reg : '0;
                    out_next.current_limit_ma = limit_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ICM_ASSERT_IMPL(a_busy_stalls, clk, rst_n, (state_reg != ST_IDLE) |-> in_stall, "busy")
    `ICM_ASSERT_IMPL(a_mode_legal, clk, rst_n, out_valid |-> (out_data.mode != MODE_INVALID), "bad mode")
    `ICM_ASSERT_IMPL(a_no_write_zero, clk, rst_n, (out_valid && !out_data.pwm_write) |-> (out_data.pwm_value == '0), "stray pwm")
    `ICM_ASSERT_IMPL(a_limit_sat, clk, rst_n, 1'b1 |-> (limit_reg <= LIMIT_CEIL), "limit too high")

endmodule

FILE: rtl/core/icm_divider.sv
module icm_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [icm_pkg::DIV_NUM_W-1:0] numer,
    input  logic [15:0] denom,
    output logic        busy,
    output logic [icm_pkg::DIV_NUM_W-1:0] quot
);
    import icm_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     count_reg, count_next;
    logic [DIV_NUM_W-1:0] quot_reg, quot_next;
    logic [16:0]          rem_reg, rem_next;
    logic [15:0]          den_reg, den_next;
    logic [16:0]          trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    always_comb
    begin
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        trial      = {rem_reg[15:0], quot_reg[DIV_NUM_W-1]};
        if (start)
        begin
            count_next = CNT_W'(DIV_NUM_W);
            quot_next  = numer;
            rem_next   = '0;
            den_next   = denom;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = trial - {1'b0, den_reg};
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    assign busy = (count_reg != '0);
    assign quot = quot_reg;

endmodule
